// ----- hdl/spin_direction_detector_assert.svh -----
// Assertion macros for the spin direction detector.
`ifndef SPIN_DIRECTION_DETECTOR_ASSERT_SVH
`define SPIN_DIRECTION_DETECTOR_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every clock edge outside reset.
`define SPD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("spin_direction_detector: assertion failed");

// Condition must never be true outside reset.
`define SPD_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("spin_direction_detector: forbidden condition seen");

`else

`define SPD_ASSERT(lbl, clk, rstn, prop)
`define SPD_ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

// ----- hdl/spd_pkg.sv -----
// Shared types and constants of the spin direction detector.
package spd_pkg;

  localparam int YAW_W    = 16;
  localparam int EL_W     = 16;
  localparam int SLOPE_W  = 24;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W    = 24;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_SPIN_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUTLIER_MARGIN = 2'd1;

  localparam logic [CFG_W-1:0] SPIN_THRESHOLD_RST = 24'd2560;
  localparam logic [CFG_W-1:0] OUTLIER_MARGIN_RST = 24'd5120;

  // direction codes
  localparam logic signed [1:0] DIR_CW   = -2'sd1;
  localparam logic signed [1:0] DIR_NONE = 2'sd0;
  localparam logic signed [1:0] DIR_CCW  = 2'sd1;

  typedef struct packed {
    logic signed [YAW_W-1:0] yaw_sample;
    logic [EL_W-1:0]         elapsed_ms;
  } spd_in_t;

  typedef struct packed {
    logic signed [1:0]      spin_dir;
    logic [SLOPE_W-1:0]     avg_slope;
  } spd_out_t;

  // divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_USE,
    S_SLOPE,
    S_AVG,
    S_MEAN,
    S_DONE
  } spd_state_e;

endpackage

// ----- hdl/spd_ram.sv -----
// Generic single write port, single read port RAM with registered read.
module spd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 10
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/spd_div.sv -----
// Iterative restoring divider, two quotient bits per cycle.
module spd_div #(
  parameter int N_W = 28
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [N_W-1:0]         dividend_i,
  input  logic [spd_pkg::EL_W-1:0] divisor_i,
  output spd_pkg::div_stat_t     stat_o,
  output logic [N_W-1:0]         quotient_o
);
  import spd_pkg::*;

  localparam int NP   = N_W + (N_W % 2);
  localparam int ITER = NP / 2;
  localparam int CW   = $clog2(ITER + 1);

  logic [NP-1:0]   quo_q, quo_d;
  logic [EL_W-1:0] rem_q, rem_d;
  logic [EL_W-1:0] dvs_q;
  logic [CW-1:0]   cnt_q;
  logic            busy_q, done_q;

  // two dependent shift-subtract steps
  always_comb begin
    logic [EL_W:0] sh;
    quo_d = quo_q;
    rem_d = rem_q;
    for (int k = 0; k < 2; k++) begin
      sh    = {rem_d, quo_d[NP-1]};
      quo_d = {quo_d[NP-2:0], 1'b0};
      if (sh >= {1'b0, dvs_q}) begin
        sh       = sh - {1'b0, dvs_q};
        quo_d[0] = 1'b1;
      end
      rem_d = sh[EL_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(ITER);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      quo_q <= NP'(dividend_i);
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q[N_W-1:0];

endmodule

// ----- hdl/spin_direction_detector.sv -----
// Spin direction detector top level: window store, sequencer and shared divider.
//
// Each request carries a yaw sample and the milliseconds since the last one. The
// sample goes into a circular window of the newest WINDOW yaws held in a small
// RAM; the window is then walked oldest first, one entry per read, and each
// adjacent pair gives a slope |diff|*256/elapsed_ms computed on one shared
// iterative divider (two quotient bits per cycle). Slopes under max(2*avg,
// avg+outlier_margin) are summed, counted and vote on direction; the same
// divider then forms sum/count. While a request is processed in_ready_o is low.
// The result sits in an output register, so the next request is taken while it
// waits. Reset needs no clearing pass: a fill count marks the valid window
// entries. Configuration is to be written through cfg_we_i/cfg_idx_i/cfg_data_i
// only while idle; the block itself does not enforce this.
`include "spin_direction_detector_assert.svh"

module spin_direction_detector #(
  parameter int WINDOW = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  spd_pkg::spd_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output spd_pkg::spd_out_t             out_data_o,
  input  logic                          cfg_we_i,
  input  logic [spd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [spd_pkg::CFG_W-1:0]     cfg_data_i
);
  import spd_pkg::*;

  localparam int AW     = $clog2(WINDOW);
  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam int CNT_W  = $clog2(WINDOW);
  localparam int VOTE_W = CNT_W + 1;
  localparam int SUM_W  = SLOPE_W + CNT_W;
  localparam int DIV_W  = SUM_W;
  localparam int BND_W  = SLOPE_W + 1;
  localparam logic signed [VOTE_W-1:0] VOTE_ONE = VOTE_W'(1);

  spd_state_e state_q, state_d;

  logic [FILL_W-1:0]        fill_q, fill_d;
  logic [FILL_W-1:0]        left_q, left_d;
  logic [AW-1:0]            wptr_q, wptr_d;
  logic [AW-1:0]            rd_addr_q, rd_addr_d;
  logic                     first_q, first_d;
  logic                     dpos_q, dpos_d;
  logic signed [YAW_W-1:0]  prev_q, prev_d;
  logic [EL_W-1:0]          elapsed_q, elapsed_d;
  logic [BND_W-1:0]         bound_q, bound_d;
  logic [SUM_W-1:0]         sum_q, sum_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic signed [VOTE_W-1:0] vote_q, vote_d;
  logic [SLOPE_W-1:0]       avg_q, avg_d;
  logic [CFG_W-1:0]         thr_q, margin_q;
  logic                     out_valid_q, out_valid_d;
  spd_out_t                 out_data_q, out_data_d;

  logic                     in_fire;
  logic                     full;
  logic [AW-1:0]            wptr_inc;
  logic [AW-1:0]            rd_inc;
  logic [YAW_W-1:0]         rd_data;
  logic signed [YAW_W:0]    diff;
  logic signed [YAW_W:0]    ndiff;
  logic [YAW_W-1:0]         mag;
  logic [BND_W-1:0]         twice, plus;

  logic                     div_start;
  logic [DIV_W-1:0]         div_dividend;
  logic [EL_W-1:0]          div_divisor;
  div_stat_t                div_stat;
  logic [DIV_W-1:0]         div_quo;

  // window storage
  spd_ram #(
    .WIDTH(YAW_W),
    .DEPTH(WINDOW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (in_fire),
    .waddr_i(wptr_q),
    .wdata_i(in_data_i.yaw_sample),
    .raddr_i(rd_addr_q),
    .rdata_o(rd_data)
  );

  // shared divider for slopes and the mean
  spd_div #(
    .N_W(DIV_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .stat_o    (div_stat),
    .quotient_o(div_quo)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign full       = (fill_q == FILL_W'(WINDOW));
  assign wptr_inc   = (wptr_q == AW'(WINDOW - 1)) ? '0 : wptr_q + 1'b1;
  assign rd_inc     = (rd_addr_q == AW'(WINDOW - 1)) ? '0 : rd_addr_q + 1'b1;

  // pair difference and its magnitude
  assign diff  = {rd_data[YAW_W-1], rd_data} - {prev_q[YAW_W-1], prev_q};
  assign ndiff = -diff;
  assign mag   = diff[YAW_W] ? ndiff[YAW_W-1:0] : diff[YAW_W-1:0];

  // outlier bound from the previous average
  assign twice = {avg_q, 1'b0};
  assign plus  = BND_W'(avg_q) + BND_W'(margin_q);

  // sequencer
  always_comb begin
    state_d      = state_q;
    fill_d       = fill_q;
    left_d       = left_q;
    wptr_d       = wptr_q;
    rd_addr_d    = rd_addr_q;
    first_d      = first_q;
    dpos_d       = dpos_q;
    prev_d       = prev_q;
    elapsed_d    = elapsed_q;
    bound_d      = bound_q;
    sum_d        = sum_q;
    cnt_d        = cnt_q;
    vote_d       = vote_q;
    avg_d        = avg_q;
    out_data_d   = out_data_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    div_start    = 1'b0;
    div_dividend = DIV_W'({mag, 8'h00});
    div_divisor  = elapsed_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          wptr_d    = wptr_inc;
          rd_addr_d = full ? wptr_inc : '0;
          left_d    = full ? FILL_W'(WINDOW) : fill_q + 1'b1;
          fill_d    = full ? fill_q : fill_q + 1'b1;
          first_d   = 1'b1;
          elapsed_d = in_data_i.elapsed_ms;
          bound_d   = (twice > plus) ? twice : plus;
          sum_d     = '0;
          cnt_d     = '0;
          vote_d    = '0;
          state_d   = S_FETCH;
        end
      end
      S_FETCH: begin
        state_d = S_USE;
      end
      S_USE: begin
        prev_d    = signed'(rd_data);
        first_d   = 1'b0;
        rd_addr_d = rd_inc;
        left_d    = left_q - 1'b1;
        if (first_q || elapsed_q == '0) begin
          // no slope for this entry
          state_d = (left_q == FILL_W'(1)) ? S_AVG : S_FETCH;
        end else begin
          dpos_d    = !diff[YAW_W] && (diff != '0);
          div_start = 1'b1;
          state_d   = S_SLOPE;
        end
      end
      S_SLOPE: begin
        if (div_stat.done) begin
          if (div_quo < DIV_W'(bound_q)) begin
            sum_d  = sum_q + div_quo;
            cnt_d  = cnt_q + 1'b1;
            vote_d = dpos_q ? vote_q + VOTE_ONE : vote_q - VOTE_ONE;
          end
          state_d = (left_q == '0) ? S_AVG : S_FETCH;
        end
      end
      S_AVG: begin
        if (cnt_q == '0) begin
          avg_d   = '0;
          state_d = S_DONE;
        end else begin
          div_start    = 1'b1;
          div_dividend = sum_q;
          div_divisor  = EL_W'(cnt_q);
          state_d      = S_MEAN;
        end
      end
      S_MEAN: begin
        if (div_stat.done) begin
          avg_d   = (|div_quo[DIV_W-1:SLOPE_W]) ? '1 : div_quo[SLOPE_W-1:0];
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // hand over once the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d          = 1'b1;
          out_data_d.avg_slope = avg_q;
          if (avg_q > thr_q && vote_q < 0) begin
            out_data_d.spin_dir = DIR_CW;
          end else if (avg_q > thr_q && vote_q > 0) begin
            out_data_d.spin_dir = DIR_CCW;
          end else begin
            out_data_d.spin_dir = DIR_NONE;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      wptr_q      <= '0;
      avg_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      wptr_q      <= wptr_d;
      avg_q       <= avg_d;
      out_valid_q <= out_valid_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    left_q     <= left_d;
    rd_addr_q  <= rd_addr_d;
    first_q    <= first_d;
    dpos_q     <= dpos_d;
    prev_q     <= prev_d;
    elapsed_q  <= elapsed_d;
    bound_q    <= bound_d;
    sum_q      <= sum_d;
    cnt_q      <= cnt_d;
    vote_q     <= vote_d;
    out_data_q <= out_data_d;
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= SPIN_THRESHOLD_RST;
      margin_q <= OUTLIER_MARGIN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SPIN_THRESHOLD: thr_q    <= cfg_data_i;
        REG_OUTLIER_MARGIN: margin_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // checks
  `SPD_ASSERT_NEVER(a_fill_range, clk_i, rst_ni, fill_q > FILL_W'(WINDOW))
  `SPD_ASSERT(a_idle_div_free, clk_i, rst_ni, in_ready_o |-> !div_stat.busy)
  `SPD_ASSERT(a_accept_fetch, clk_i, rst_ni, in_fire |=> (state_q == S_FETCH))
  `SPD_ASSERT(a_done_in_wait, clk_i, rst_ni,
              div_stat.done |-> (state_q == S_SLOPE || state_q == S_MEAN))

endmodule
